### hdl/tsc_pkg.sv
// ---------------------------------------------------------------------------
// tsc_pkg
// Shared types and constants for the TIMEA sentence capture block.
// ---------------------------------------------------------------------------
package tsc_pkg;

	localparam int BUF_DEPTH = 128;
	localparam int ADDR_W    = $clog2(BUF_DEPTH);
	localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
	localparam int LEN_W     = 8;

	localparam logic [7:0] CH_T  = 8'h54;
	localparam logic [7:0] CH_I  = 8'h49;
	localparam logic [7:0] CH_M  = 8'h4D;
	localparam logic [7:0] CH_E  = 8'h45;
	localparam logic [7:0] CH_A  = 8'h41;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	typedef enum logic [1:0] {
		REQ_BYTE    = 2'd0,
		REQ_TAKE    = 2'd1,
		REQ_READ    = 2'd2,
		REQ_RELEASE = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		EV_IGNORED   = 4'd0,
		EV_STORED    = 4'd1,
		EV_CR        = 4'd2,
		EV_COMPLETE  = 4'd3,
		EV_ABORTED   = 4'd4,
		EV_TAKEN     = 4'd5,
		EV_TAKE_FAIL = 4'd6,
		EV_READ      = 4'd7,
		EV_RELEASED  = 4'd8
	} event_t;

	// expected header letter at a fill position; valid is low where none fits
	typedef struct packed {
		logic       valid;
		logic [7:0] ch;
	} hdr_char_t;

	function automatic hdr_char_t header_char(input logic [CNT_W-1:0] pos);
		hdr_char_t r;
		r.valid = 1'b1;
		case (pos)
			CNT_W'(1): r.ch = CH_I;
			CNT_W'(2): r.ch = CH_M;
			CNT_W'(3): r.ch = CH_E;
			CNT_W'(4): r.ch = CH_A;
			default: begin
				r.valid = 1'b0;
				r.ch    = 8'h00;
			end
		endcase
		return r;
	endfunction

endpackage

### hdl/timea_sentence_capture.sv
// ---------------------------------------------------------------------------
// timea_sentence_capture
// Captures one "TIMEA" sentence from a received byte stream into a buffer.
// ---------------------------------------------------------------------------
// One transaction in, one result out. A new transaction is taken every cycle
// while results drain; each passes first through the stage for the flag
// update and buffer access (synchronous RAM with one write and one read
// port, registered read), then through the output register. The input
// stalls only while both stages hold a result and m_tready is low. The
// buffer needs no clearing pass.
module timea_sentence_capture
	import tsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] rx_byte, [14:8] read_index, [15] zero
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] frame_length, [15:8] read_data,
	                               // [16] frame_ready, [23:17] zero
	output logic [3:0]  m_tuser    // [3:0] event_res
);

	logic [7:0]        byte_store [BUF_DEPTH];

	logic [CNT_W-1:0]  fill_q;
	logic              hdr_q, cr_q, done_q, busy_q;

	logic [CNT_W-1:0]  fill_d;
	logic              hdr_d, cr_d, done_d, busy_d;
	event_t            ev_d;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;

	logic              v_s1;
	event_t            ev_s1;
	logic [LEN_W-1:0]  len_s1;
	logic              rdy_s1;
	logic              rd_s1;
	logic [7:0]        rdata_s1;

	logic              out_v_q;
	event_t            ev_q;
	logic [LEN_W-1:0]  len_q;
	logic [7:0]        data_q;
	logic              rdy_q;

	req_t              req;
	logic [7:0]        rx_byte;
	logic [6:0]        read_index;
	hdr_char_t         hc;
	logic              acc, move_s1;

	assign req        = req_t'(s_tuser);
	assign rx_byte    = s_tdata[7:0];
	assign read_index = s_tdata[14:8];
	assign hc         = header_char(fill_q);

	assign move_s1  = v_s1 && (!out_v_q || m_tready);
	assign s_tready = !v_s1 || !out_v_q || m_tready;
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		fill_d  = fill_q;
		hdr_d   = hdr_q;
		cr_d    = cr_q;
		done_d  = done_q;
		busy_d  = busy_q;
		ev_d    = EV_IGNORED;
		wr_en   = 1'b0;
		wr_addr = fill_q[ADDR_W-1:0];
		case (req)
			REQ_BYTE: begin
				if (busy_q) begin
					ev_d = EV_IGNORED;
				end else if (hdr_q) begin
					if (cr_q) begin
						if (rx_byte == CH_LF) begin
							done_d = 1'b1;
							hdr_d  = 1'b0;
							cr_d   = 1'b0;
							ev_d   = EV_COMPLETE;
						end else begin
							fill_d = '0;
							hdr_d  = 1'b0;
							cr_d   = 1'b0;
							done_d = 1'b0;
							busy_d = 1'b0;
							ev_d   = EV_ABORTED;
						end
					end else if (rx_byte == CH_CR) begin
						cr_d = 1'b1;
						ev_d = EV_CR;
					end else if (fill_q >= CNT_W'(BUF_DEPTH)) begin
						fill_d = '0;
						hdr_d  = 1'b0;
						cr_d   = 1'b0;
						done_d = 1'b0;
						busy_d = 1'b0;
						ev_d   = EV_ABORTED;
					end else begin
						wr_en  = 1'b1;
						fill_d = fill_q + CNT_W'(1);
						ev_d   = EV_STORED;
					end
				end else if (rx_byte == CH_T) begin
					wr_en   = 1'b1;
					wr_addr = '0;
					fill_d  = CNT_W'(1);
					ev_d    = EV_STORED;
				end else if (fill_q != '0 && fill_q < CNT_W'(BUF_DEPTH) &&
						hc.valid && rx_byte == hc.ch) begin
					wr_en  = 1'b1;
					fill_d = fill_q + CNT_W'(1);
					ev_d   = EV_STORED;
					if (rx_byte == CH_A) begin
						done_d = 1'b0;
						hdr_d  = 1'b1;
					end
				end
			end
			REQ_TAKE: begin
				if (done_q) begin
					done_d = 1'b0;
					busy_d = 1'b1;
					ev_d   = EV_TAKEN;
				end else begin
					ev_d = EV_TAKE_FAIL;
				end
			end
			REQ_READ: begin
				ev_d = EV_READ;
			end
			default: begin
				fill_d = '0;
				hdr_d  = 1'b0;
				cr_d   = 1'b0;
				done_d = 1'b0;
				busy_d = 1'b0;
				ev_d   = EV_RELEASED;
			end
		endcase
	end

	// buffer RAM: the write of one transaction lands before any later read
	always_ff @(posedge clk) begin
		if (acc && wr_en) begin
			byte_store[wr_addr] <= rx_byte;
		end
		if (acc) begin
			rdata_s1 <= byte_store[read_index[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			hdr_q   <= 1'b0;
			cr_q    <= 1'b0;
			done_q  <= 1'b0;
			busy_q  <= 1'b0;
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (acc) begin
				fill_q <= fill_d;
				hdr_q  <= hdr_d;
				cr_q   <= cr_d;
				done_q <= done_d;
				busy_q <= busy_d;
				v_s1   <= 1'b1;
			end else if (move_s1) begin
				v_s1 <= 1'b0;
			end
			if (move_s1) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ev_s1  <= ev_d;
			len_s1 <= LEN_W'(fill_d);
			rdy_s1 <= done_d;
			rd_s1  <= (req == REQ_READ) && ({1'b0, read_index} < 8'(BUF_DEPTH));
		end
		if (move_s1) begin
			ev_q   <= ev_s1;
			len_q  <= len_s1;
			rdy_q  <= rdy_s1;
			data_q <= rd_s1 ? rdata_s1 : 8'h00;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = ev_q;
	assign m_tdata  = {7'd0, rdy_q, data_q, len_q};

endmodule

### hdl/tsc_chk.sv
// ---------------------------------------------------------------------------
// tsc_chk
// Port-level checks for timea_sentence_capture, bound to the top level.
// ---------------------------------------------------------------------------
module tsc_chk
	import tsc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [3:0]  m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_data_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != EV_READ |-> m_tdata[15:8] == 8'h00)
		else $error("read_data nonzero outside a read");

	a_taken_clears_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == EV_TAKEN |-> !m_tdata[16])
		else $error("frame_ready still set after take");

	a_clear_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == EV_RELEASED || m_tuser == EV_ABORTED)
		|-> m_tdata[7:0] == 8'h00 && !m_tdata[16])
		else $error("state not cleared on release or abort");

	a_complete_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == EV_COMPLETE |-> m_tdata[16])
		else $error("frame_ready missing on completion");

endmodule

bind timea_sentence_capture tsc_chk u_tsc_chk (.*);
